// ----- design/dvt_pkg.sv -----
// shared types and constants of the distance-vector table merge unit
`default_nettype none

package dvt_pkg;

    localparam int NET_W    = 4;
    localparam int RTR_W    = 3;
    localparam int HOP_W    = 4;
    localparam int WD_W     = 5;
    // widest compare width for range checks on network and router numbers
    localparam int RANGE_W  = 9;

    localparam int ROUTER_COUNT = 8;
    localparam int MAX_HOPS     = 15;

    typedef struct packed {
        logic [RTR_W-1:0] sender_id;
        logic [NET_W-1:0] dest_net;
        logic [HOP_W-1:0] adv_hops;
        logic             last_entry;
    } dvt_adv_t;

    typedef struct packed {
        logic [NET_W-1:0] dest_net_out;
        logic [HOP_W-1:0] hops_out;
        logic [RTR_W-1:0] next_hop_out;
        logic             changed;
        logic [WD_W-1:0]  withdrawn_count;
    } dvt_res_t;

    typedef struct packed {
        logic [HOP_W-1:0] hops;
        logic [RTR_W-1:0] next_hop;
    } dvt_route_t;

endpackage

`default_nettype wire

// ----- design/dvt_stream_if.sv -----
// valid/ready channel interface carrying one item per handshake
`default_nettype none

interface dvt_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- design/distance_vector_table_merge_unit.sv -----
// distance-vector route table merge unit, top level
`default_nettype none

// Merges a neighbour's advertisement into the route table one entry per item.
// The route memory is read at the edge that accepts an item. The entry is compared
// and written back in the next cycle, and an ordinary entry's result is registered
// at the end of that update step. The unit takes no new item until it is back in
// idle. The last entry of an advertisement also runs the withdrawal sweep.
// After a setup step, the sweep walks the route memory one network per cycle
// through the same read port, and that item's result is registered in the done
// step that follows. A new item is accepted while the previous result is being
// taken; there is no clearing pass after reset.
module distance_vector_table_merge_unit #(
    parameter int NET_COUNT = 16
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    dvt_stream_if.sink   advert,
    dvt_stream_if.source result
);
    import dvt_pkg::*;

    localparam int IDX_W = (NET_COUNT > 1) ? $clog2(NET_COUNT) : 1;
    localparam int CNT_W = $clog2(NET_COUNT + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_SWEEP_PREP,
        ST_SWEEP,
        ST_DONE
    } state_t;

    state_t             state_reg;
    dvt_adv_t           item_reg;
    logic [IDX_W-1:0]   item_idx_reg;
    logic               item_ok_reg;
    logic [IDX_W-1:0]   sweep_idx_reg;
    logic [CNT_W-1:0]   wd_count_reg;
    logic [NET_COUNT-1:0] valid_reg;
    logic [NET_COUNT-1:0] seen_reg;
    logic               out_valid_reg;
    dvt_res_t           out_reg;

    dvt_route_t         route_mem [NET_COUNT];
    dvt_route_t         rd_data_reg;

    logic               take;
    logic               out_free;
    logic [RANGE_W-1:0] in_dest_ext;
    logic [RANGE_W-1:0] in_sender_ext;
    logic               in_ok;
    logic [IDX_W-1:0]   in_idx;
    logic [IDX_W-1:0]   rd_addr;
    logic [HOP_W:0]     cost_sum;
    logic [HOP_W-1:0]   cost;
    logic               install;
    logic               withdraw;
    logic [RANGE_W-1:0] wd_count_ext;

    assign out_free      = !out_valid_reg || result.ready;
    assign advert.ready  = (state_reg == ST_IDLE) && out_free;
    assign take          = advert.valid && advert.ready;
    assign result.valid  = out_valid_reg;
    assign result.payload = out_reg;

    assign in_dest_ext   = RANGE_W'(advert.payload.dest_net);
    assign in_sender_ext = RANGE_W'(advert.payload.sender_id);
    assign in_ok         = (in_dest_ext < RANGE_W'(NET_COUNT))
                        && (in_sender_ext < RANGE_W'(ROUTER_COUNT));
    assign in_idx        = in_dest_ext[IDX_W-1:0];

    // saturating cost through the sender
    assign cost_sum = {1'b0, item_reg.adv_hops} + (HOP_W+1)'(1);
    assign cost     = (cost_sum > (HOP_W+1)'(MAX_HOPS)) ? HOP_W'(MAX_HOPS)
                                                        : cost_sum[HOP_W-1:0];
    assign install  = item_ok_reg
                   && (!valid_reg[item_idx_reg] || (cost < rd_data_reg.hops));

    assign withdraw = valid_reg[sweep_idx_reg]
                   && (rd_data_reg.next_hop == item_reg.sender_id)
                   && !seen_reg[sweep_idx_reg];

    assign wd_count_ext = RANGE_W'(wd_count_reg);

    always_comb
    begin
        unique case (state_reg)
            ST_IDLE:       rd_addr = in_idx;
            ST_SWEEP:      rd_addr = sweep_idx_reg + IDX_W'(1);
            default:       rd_addr = '0;
        endcase
    end

    // route memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_UPDATE && install)
        begin
            route_mem[item_idx_reg] <= '{hops: cost, next_hop: item_reg.sender_id};
        end
        rd_data_reg <= route_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            item_reg      <= '0;
            item_idx_reg  <= '0;
            item_ok_reg   <= 1'b0;
            sweep_idx_reg <= '0;
            wd_count_reg  <= '0;
            valid_reg     <= '0;
            seen_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            if (out_valid_reg && result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (take)
                    begin
                        item_reg     <= advert.payload;
                        item_idx_reg <= in_idx;
                        item_ok_reg  <= in_ok;
                        state_reg    <= ST_UPDATE;
                    end
                end
                ST_UPDATE:
                begin
                    out_reg.dest_net_out    <= item_reg.dest_net;
                    out_reg.withdrawn_count <= '0;
                    if (!item_ok_reg)
                    begin
                        out_reg.hops_out     <= '0;
                        out_reg.next_hop_out <= '0;
                        out_reg.changed      <= 1'b0;
                    end
                    else
                    begin
                        seen_reg[item_idx_reg] <= 1'b1;
                        if (install)
                        begin
                            valid_reg[item_idx_reg] <= 1'b1;
                            out_reg.hops_out        <= cost;
                            out_reg.next_hop_out    <= item_reg.sender_id;
                            out_reg.changed         <= 1'b1;
                        end
                        else
                        begin
                            out_reg.hops_out     <= rd_data_reg.hops;
                            out_reg.next_hop_out <= rd_data_reg.next_hop;
                            out_reg.changed      <= 1'b0;
                        end
                    end
                    if (item_reg.last_entry)
                    begin
                        state_reg <= ST_SWEEP_PREP;
                    end
                    else
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                ST_SWEEP_PREP:
                begin
                    // read of network 0 is issued here, after the write back
                    sweep_idx_reg <= '0;
                    wd_count_reg  <= '0;
                    state_reg     <= ST_SWEEP;
                end
                ST_SWEEP:
                begin
                    if (withdraw)
                    begin
                        valid_reg[sweep_idx_reg] <= 1'b0;
                        wd_count_reg             <= wd_count_reg + CNT_W'(1);
                    end
                    seen_reg[sweep_idx_reg] <= 1'b0;
                    sweep_idx_reg           <= sweep_idx_reg + IDX_W'(1);
                    if (sweep_idx_reg == IDX_W'(NET_COUNT - 1))
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    out_reg.withdrawn_count <= wd_count_ext[WD_W-1:0];
                    out_valid_reg           <= 1'b1;
                    state_reg               <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // an accepted item always moves on to the update step
    assert property (@(posedge clk) disable iff (!rst_n)
        advert.valid && advert.ready |=> state_reg == ST_UPDATE)
        else $error("accepted item did not enter update");

    // results come only from the update step or the end of a sweep
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> $past(state_reg) == ST_UPDATE
                             || $past(state_reg) == ST_DONE)
        else $error("result appeared outside update or sweep end");

    // a finished sweep leaves no seen marks behind
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DONE |-> seen_reg == '0)
        else $error("seen marks left after sweep");

    // withdrawals are reported only on the last entry
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> item_reg.last_entry
                      || result.payload.withdrawn_count == '0)
        else $error("withdrawal count on an ordinary entry");

endmodule

`default_nettype wire

// ----- tb/distance_vector_table_merge_unit_tb.sv -----
// testbench for the distance-vector route table merge unit
module distance_vector_table_merge_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dvt_pkg::*;

    localparam int NET_COUNT     = 16;
    localparam int TARGET_ITEMS  = 550;
    localparam int LONG_HOLD     = 300;
    localparam int MAX_REPORTS   = 10;
    localparam int DRAIN_CYCLES  = 2 * (NET_COUNT + 4);
    localparam int DIRECTED_ROWS = 21;

    typedef struct packed {
        logic [RTR_W-1:0] snd;
        logic [NET_W-1:0] net;
        logic [HOP_W-1:0] adv;
        logic             last;
        logic             typed;
        dvt_res_t         want;
    } directed_row_t;

    // want = dest_net_out, hops_out, next_hop_out, changed, withdrawn_count
    localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{3'd0, 4'd0,  4'd0,  1'b0, 1'b1, '{4'd0,  4'd1,  3'd0, 1'b1, 5'd0}},
        // install saturates at the hop limit
        '{3'd7, 4'd15, 4'd15, 1'b0, 1'b1, '{4'd15, 4'd15, 3'd7, 1'b1, 5'd0}},
        '{3'd3, 4'd15, 4'd14, 1'b0, 1'b1, '{4'd15, 4'd15, 3'd7, 1'b0, 5'd0}},
        '{3'd3, 4'd15, 4'd13, 1'b0, 1'b1, '{4'd15, 4'd14, 3'd3, 1'b1, 5'd0}},
        // equal cost from another sender, then from the current next hop
        '{3'd5, 4'd15, 4'd13, 1'b0, 1'b1, '{4'd15, 4'd14, 3'd3, 1'b0, 5'd0}},
        '{3'd3, 4'd15, 4'd13, 1'b0, 1'b1, '{4'd15, 4'd14, 3'd3, 1'b0, 5'd0}},
        // last item marks its own network before the sweep
        '{3'd3, 4'd1,  4'd2,  1'b1, 1'b1, '{4'd1,  4'd3,  3'd3, 1'b1, 5'd0}},
        '{3'd3, 4'd2,  4'd0,  1'b1, 1'b1, '{4'd2,  4'd1,  3'd3, 1'b1, 5'd2}},
        // mark left by another sender protects the route through sender 0
        '{3'd2, 4'd0,  4'd4,  1'b0, 1'b1, '{4'd0,  4'd1,  3'd0, 1'b0, 5'd0}},
        '{3'd0, 4'd5,  4'd7,  1'b1, 1'b1, '{4'd5,  4'd8,  3'd0, 1'b1, 5'd0}},
        // own network loaded as a hop-0 advert from self
        '{3'd6, 4'd6,  4'd0,  1'b0, 1'b1, '{4'd6,  4'd1,  3'd6, 1'b1, 5'd0}},
        '{3'd4, 4'd3,  4'd0,  1'b0, 1'b0, '0},
        '{3'd4, 4'd4,  4'd0,  1'b0, 1'b0, '0},
        '{3'd4, 4'd7,  4'd0,  1'b0, 1'b0, '0},
        '{3'd4, 4'd8,  4'd0,  1'b0, 1'b0, '0},
        '{3'd4, 4'd9,  4'd0,  1'b0, 1'b0, '0},
        '{3'd4, 4'd10, 4'd0,  1'b0, 1'b0, '0},
        '{3'd4, 4'd11, 4'd1,  1'b1, 1'b0, '0},
        // second advert from sender 4 drops most of its routes
        '{3'd4, 4'd12, 4'd0,  1'b1, 1'b0, '0},
        '{3'd1, 4'd15, 4'd0,  1'b0, 1'b0, '0},
        '{3'd1, 4'd15, 4'd0,  1'b1, 1'b0, '0}
    };

    logic clk;
    logic rst_n;

    dvt_stream_if #(.payload_t(dvt_adv_t)) advert_ch ();
    dvt_stream_if #(.payload_t(dvt_res_t)) result_ch ();

    distance_vector_table_merge_unit #(
        .NET_COUNT(NET_COUNT)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .advert(advert_ch),
        .result(result_ch)
    );

    // mirror of the route table
    logic             net_valid [NET_COUNT];
    logic [HOP_W-1:0] net_hops  [NET_COUNT];
    logic [RTR_W-1:0] net_via   [NET_COUNT];
    logic             net_seen  [NET_COUNT];

    dvt_res_t pending_updates [$];

    int  accepted_cnt   = 0;
    int  report_cnt     = 0;
    int  mismatch_cnt   = 0;
    int  sweep_cnt      = 0;
    int  withdraw_total = 0;
    bit  source_burst   = 1'b0;
    bit  sink_burst     = 1'b0;
    logic hold_out;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic dvt_res_t merge_advert_entry(dvt_adv_t e);
        dvt_res_t         r;
        logic [HOP_W:0]   cost;
        logic [WD_W-1:0]  dropped;
        r = '0;
        r.dest_net_out = e.dest_net;
        if (int'(e.dest_net) < NET_COUNT && int'(e.sender_id) < ROUTER_COUNT)
        begin
            cost = {1'b0, e.adv_hops} + 1'b1;
            if (cost > MAX_HOPS)
                cost = (HOP_W+1)'(MAX_HOPS);
            if (!net_valid[e.dest_net] || cost < {1'b0, net_hops[e.dest_net]})
            begin
                net_valid[e.dest_net] = 1'b1;
                net_hops[e.dest_net]  = cost[HOP_W-1:0];
                net_via[e.dest_net]   = e.sender_id;
                r.changed             = 1'b1;
            end
            net_seen[e.dest_net] = 1'b1;
            r.hops_out           = net_hops[e.dest_net];
            r.next_hop_out       = net_via[e.dest_net];
        end
        if (e.last_entry)
        begin
            dropped = '0;
            for (int n = 0; n < NET_COUNT; n++)
            begin
                if (net_valid[n] && net_via[n] == e.sender_id && !net_seen[n])
                begin
                    net_valid[n] = 1'b0;
                    dropped++;
                end
                net_seen[n] = 1'b0;
            end
            r.withdrawn_count = dropped;
            sweep_cnt++;
            withdraw_total += dropped;
        end
        return r;
    endfunction

    task automatic note_mismatch(string what, dvt_res_t want, dvt_res_t got);
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS)
        begin
            $write("%0t %s: expected net %0d hops %0d nh %0d chg %0b wd %0d,",
                   $time, what, want.dest_net_out, want.hops_out, want.next_hop_out,
                   want.changed, want.withdrawn_count);
            $display(" got net %0d hops %0d nh %0d chg %0b wd %0d",
                     got.dest_net_out, got.hops_out, got.next_hop_out, got.changed,
                     got.withdrawn_count);
        end
    endtask

    task automatic offer_entry(input dvt_adv_t entry, input bit typed, input dvt_res_t typed_res);
        int unsigned gap;
        dvt_res_t    predicted;
        dvt_res_t    expected;
        if (accepted_cnt % 40 == 0)
            source_burst = ($urandom_range(0, 3) == 0);
        gap = source_burst ? 0 : $urandom_range(0, 13);
        if (gap != 0)
        begin
            advert_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        advert_ch.valid   <= 1'b1;
        advert_ch.payload <= entry;
        @(posedge clk);
        while (!advert_ch.ready)
            @(posedge clk);
        predicted = merge_advert_entry(entry);
        expected  = typed ? typed_res : predicted;
        pending_updates = {pending_updates, expected};
        accepted_cnt++;
    endtask

    // stimulus
    initial
    begin
        dvt_adv_t         entry;
        dvt_res_t         want;
        logic [RTR_W-1:0] sender;
        int               span;
        bit               noisy;
        int               i;
        int               k;
        rst_n             = 1'b0;
        advert_ch.valid   = 1'b0;
        advert_ch.payload = '0;
        for (i = 0; i < NET_COUNT; i++)
        begin
            net_valid[i] = 1'b0;
            net_hops[i]  = '0;
            net_via[i]   = '0;
            net_seen[i]  = 1'b0;
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < DIRECTED_ROWS; i++)
        begin
            entry.sender_id  = DIRECTED[i].snd;
            entry.dest_net   = DIRECTED[i].net;
            entry.adv_hops   = DIRECTED[i].adv;
            entry.last_entry = DIRECTED[i].last;
            want             = DIRECTED[i].want;
            offer_entry(entry, DIRECTED[i].typed, want);
        end

        // mostly whole adverts; about one in ten is broken or mixed
        while (accepted_cnt < TARGET_ITEMS)
        begin
            sender = RTR_W'($urandom_range(0, ROUTER_COUNT - 1));
            span   = $urandom_range(1, 10);
            noisy  = ($urandom_range(0, 9) == 0);
            for (k = 0; k < span; k++)
            begin
                entry.sender_id = sender;
                if (noisy && $urandom_range(0, 3) == 0)
                    entry.sender_id = RTR_W'($urandom_range(0, ROUTER_COUNT - 1));
                entry.dest_net = NET_W'($urandom_range(0, NET_COUNT - 1));
                case ($urandom_range(0, 3))
                    0:       entry.adv_hops = HOP_W'($urandom_range(0, 2));
                    3:       entry.adv_hops = HOP_W'($urandom_range(MAX_HOPS - 2, MAX_HOPS));
                    default: entry.adv_hops = HOP_W'($urandom_range(0, MAX_HOPS));
                endcase
                if (noisy)
                    entry.last_entry = ($urandom_range(0, 2) == 0);
                else
                    entry.last_entry = (k == span - 1);
                offer_entry(entry, 1'b0, '0);
            end
        end
        advert_ch.valid <= 1'b0;

        while (pending_updates.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("merged %0d advert items (%0d from the directed table), %0d route reports checked",
                 accepted_cnt, DIRECTED_ROWS, report_cnt);
        $display("%0d end-of-advert sweeps withdrew %0d routes; output held off %0d cycles once",
                 sweep_cnt, withdraw_total, LONG_HOLD);
        if (mismatch_cnt == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // result side
    initial
    begin
        int unsigned wait_cycles;
        dvt_res_t    got;
        dvt_res_t    want;
        result_ch.ready = 1'b0;
        forever
        begin
            if (report_cnt % 40 == 0)
                sink_burst = ($urandom_range(0, 3) == 0);
            wait_cycles = sink_burst ? 0 : $urandom_range(0, 13);
            if (wait_cycles != 0 || hold_out)
            begin
                result_ch.ready <= 1'b0;
                repeat (wait_cycles) @(posedge clk);
                while (hold_out)
                    @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            @(posedge clk);
            while (!result_ch.valid)
                @(posedge clk);
            got = result_ch.payload;
            report_cnt++;
            if (pending_updates.size() == 0)
            begin
                note_mismatch("unexpected item", '0, got);
            end
            else
            begin
                want = pending_updates.pop_front();
                if (got.dest_net_out !== want.dest_net_out || got.hops_out !== want.hops_out ||
                    got.next_hop_out !== want.next_hop_out || got.changed !== want.changed ||
                    got.withdrawn_count !== want.withdrawn_count)
                    note_mismatch("wrong item", want, got);
            end
        end
    end

    // long output stall so the unit backs up and drops advert ready
    initial
    begin
        hold_out = 1'b0;
        while (accepted_cnt < 120)
            @(posedge clk);
        hold_out <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_out <= 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("timeout with %0d items outstanding", pending_updates.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
